[src/lrsf_pkg.sv]
package lrsf_pkg;

	localparam int RIPPLES    = 12;
	localparam int PTR_W      = $clog2(RIPPLES);
	localparam int CENTRE_W   = 12;
	localparam int MAX_PIXELS = 1024;
	localparam int IDX_W      = 10;
	localparam int CNT_CFG_W  = 11;

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_SET   = 2'd1,
		KIND_SHOW  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_PLUS,
		ST_MINUS,
		ST_SHOW
	} state_t;

	// per-slot base colours, slots above 11 are black
	localparam logic [7:0] TAB_R [16] = '{8'd255, 8'd127, 8'd0, 8'd0, 8'd0, 8'd127, 8'd255,
		8'd127, 8'd0, 8'd0, 8'd0, 8'd127, 8'd0, 8'd0, 8'd0, 8'd0};
	localparam logic [7:0] TAB_G [16] = '{8'd0, 8'd127, 8'd255, 8'd127, 8'd0, 8'd0, 8'd0,
		8'd127, 8'd255, 8'd127, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
	localparam logic [7:0] TAB_B [16] = '{8'd0, 8'd0, 8'd0, 8'd127, 8'd255, 8'd127, 8'd0,
		8'd0, 8'd0, 8'd127, 8'd255, 8'd127, 8'd0, 8'd0, 8'd0, 8'd0};

	// 255/c and 127/c, entry 0 unused
	localparam logic [7:0] Q255 [16] = '{8'd255, 8'd255, 8'd127, 8'd85, 8'd63, 8'd51, 8'd42,
		8'd36, 8'd31, 8'd28, 8'd25, 8'd23, 8'd21, 8'd19, 8'd18, 8'd17};
	localparam logic [7:0] Q127 [16] = '{8'd127, 8'd127, 8'd63, 8'd42, 8'd31, 8'd25, 8'd21,
		8'd18, 8'd15, 8'd14, 8'd12, 8'd11, 8'd10, 8'd9, 8'd9, 8'd8};

	function automatic logic [7:0] dim(input logic [7:0] lvl, input logic [3:0] c);
		logic [7:0] r;
		begin
			if (c == 4'd0)
				r = 8'd255;
			else if (lvl == 8'd255)
				r = Q255[c];
			else if (lvl == 8'd127)
				r = Q127[c];
			else
				r = 8'd0;
			return r;
		end
	endfunction

endpackage

[src/lrsf_ram.sv]
module lrsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem_q[rd_addr];
	end

endmodule

[src/led_ripple_sparkle_frame.sv]
// Ripple sparkle frame generator. Every input beat is one frame tick carrying the centre of
// the newest ripple; it is stored in a ring of RIPPLES centres and the block then streams a
// clear beat, up to two set-pixel beats per ring slot (centre+count first, then centre-count,
// only those on the strip) and a show beat with tlast. After the tick is taken, the frame
// steps through ST_CLEAR, then ST_PLUS and ST_MINUS for every ring slot, whether or not its
// pixels are on the strip, then ST_SHOW, the ring RAM being read one slot ahead so the
// next centre is ready when the current slot is done. A full output register that is not
// drained holds the frame whenever a beat is due. A new tick can be taken from the cycle
// after the show beat has been loaded, not before. pixel_count is saturated to 1024.
module led_ripple_sparkle_frame
	import lrsf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,       // pixel_count
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,    // [11:0] new_centre
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,    // [9:0] pixel_index, [17:10] red, [25:18] green,
	                                     // [33:26] blue
	output logic [1:0]  m_axis_tuser,    // [1:0] kind
	output logic        m_axis_tlast
);

	state_t state_q, state_d;

	logic [CNT_CFG_W-1:0] pix_cnt_q;
	logic [PTR_W-1:0]     wp_q;
	logic [PTR_W-1:0]     slot_q;
	logic [PTR_W-1:0]     cnt_q;
	logic [RIPPLES-1:0]   vld_q;
	logic                 vld_s1;

	logic                 wr_en;
	logic                 rd_en;
	logic [PTR_W-1:0]     rd_addr;
	logic [CENTRE_W-1:0]  rd_data;

	logic                 out_free;
	logic                 ld;
	kind_t                ld_kind;
	logic [IDX_W-1:0]     ld_idx;
	logic                 ld_rgb;
	logic                 slot_adv;
	logic                 wp_adv;

	logic [CENTRE_W-1:0]  centre;
	logic [CENTRE_W:0]    p_plus;
	logic [CENTRE_W:0]    p_minus;
	logic [CNT_CFG_W-1:0] len;
	logic                 ok_plus;
	logic                 ok_minus;
	logic [7:0]           red, green, blue;

	logic [IDX_W-1:0]     idx_q;
	logic [7:0]           red_q, green_q, blue_q;
	kind_t                kind_q;
	logic                 last_q;
	logic                 out_vld_q;

	lrsf_ram #(.WIDTH(CENTRE_W), .DEPTH(RIPPLES)) u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wp_q),
		.wr_data (s_axis_tdata[CENTRE_W-1:0]),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// entries never written read as zero
	assign centre  = vld_s1 ? rd_data : '0;
	assign p_plus  = {centre[CENTRE_W-1], centre} + {{(CENTRE_W+1-PTR_W){1'b0}}, cnt_q};
	assign p_minus = {centre[CENTRE_W-1], centre} - {{(CENTRE_W+1-PTR_W){1'b0}}, cnt_q};
	assign len     = (pix_cnt_q > CNT_CFG_W'(MAX_PIXELS)) ? CNT_CFG_W'(MAX_PIXELS) : pix_cnt_q;
	assign ok_plus  = !p_plus[CENTRE_W] && ({1'b0, len} > p_plus[CENTRE_W-1:0]);
	assign ok_minus = !p_minus[CENTRE_W] && ({1'b0, len} > p_minus[CENTRE_W-1:0]);

	assign red   = dim(TAB_R[slot_q], cnt_q);
	assign green = dim(TAB_G[slot_q], cnt_q);
	assign blue  = dim(TAB_B[slot_q], cnt_q);

	assign out_free      = !out_vld_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d  = state_q;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = '0;
		ld       = 1'b0;
		ld_kind  = KIND_CLEAR;
		ld_idx   = '0;
		ld_rgb   = 1'b0;
		slot_adv = 1'b0;
		wp_adv   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					wr_en   = 1'b1;
					state_d = ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				if (out_free) begin
					ld      = 1'b1;
					rd_en   = 1'b1;
					state_d = ST_PLUS;
				end
			end
			ST_PLUS: begin
				if (!ok_plus) begin
					state_d = ST_MINUS;
				end else if (out_free) begin
					ld      = 1'b1;
					ld_kind = KIND_SET;
					ld_idx  = p_plus[IDX_W-1:0];
					ld_rgb  = 1'b1;
					state_d = ST_MINUS;
				end
			end
			ST_MINUS: begin
				if (!ok_minus || out_free) begin
					ld      = ok_minus;
					ld_kind = KIND_SET;
					ld_idx  = p_minus[IDX_W-1:0];
					ld_rgb  = 1'b1;
					if (slot_q == PTR_W'(RIPPLES - 1)) begin
						state_d = ST_SHOW;
					end else begin
						// fetch the next slot's centre while leaving this one
						rd_en    = 1'b1;
						rd_addr  = slot_q + 1'b1;
						slot_adv = 1'b1;
						state_d  = ST_PLUS;
					end
				end
			end
			ST_SHOW: begin
				if (out_free) begin
					ld      = 1'b1;
					ld_kind = KIND_SHOW;
					wp_adv  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pix_cnt_q <= CNT_CFG_W'(60);
			wp_q      <= '0;
			slot_q    <= '0;
			cnt_q     <= '0;
			vld_q     <= '0;
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
			kind_q    <= KIND_CLEAR;
			last_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				pix_cnt_q <= cfg_wdata;
			if (wr_en) begin
				vld_q[wp_q] <= 1'b1;
				slot_q      <= '0;
				cnt_q       <= wp_q;
			end
			if (slot_adv) begin
				slot_q <= slot_q + 1'b1;
				cnt_q  <= (cnt_q == PTR_W'(RIPPLES - 1)) ? '0 : cnt_q + 1'b1;
			end
			if (wp_adv)
				wp_q <= (wp_q == PTR_W'(RIPPLES - 1)) ? '0 : wp_q + 1'b1;
			if (rd_en)
				vld_s1 <= vld_q[rd_addr];
			if (ld) begin
				out_vld_q <= 1'b1;
				kind_q    <= ld_kind;
				last_q    <= (ld_kind == KIND_SHOW);
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			idx_q   <= ld_idx;
			red_q   <= ld_rgb ? red : 8'd0;
			green_q <= ld_rgb ? green : 8'd0;
			blue_q  <= ld_rgb ? blue : 8'd0;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {6'd0, blue_q, green_q, red_q, idx_q};
	assign m_axis_tuser  = kind_q;
	assign m_axis_tlast  = last_q;

endmodule

[dv/led_ripple_sparkle_frame_test.sv]
`timescale 1ns / 1ps

module led_ripple_sparkle_frame_test;
	import lrsf_pkg::*;

	localparam int FRAME_CYCLES = 2 + 2 * RIPPLES;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int SETTLE_CAP   = 50000;

	typedef struct packed {
		kind_t            kind;
		logic [IDX_W-1:0] pixel;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic             last;
	} led_beat_t;

	// base hue of each ring slot before dimming
	localparam logic [7:0] HUE_R [RIPPLES] = '{8'd255, 8'd127, 8'd0, 8'd0, 8'd0, 8'd127,
		8'd255, 8'd127, 8'd0, 8'd0, 8'd0, 8'd127};
	localparam logic [7:0] HUE_G [RIPPLES] = '{8'd0, 8'd127, 8'd255, 8'd127, 8'd0, 8'd0,
		8'd0, 8'd127, 8'd255, 8'd127, 8'd0, 8'd0};
	localparam logic [7:0] HUE_B [RIPPLES] = '{8'd0, 8'd0, 8'd0, 8'd127, 8'd255, 8'd127,
		8'd0, 8'd0, 8'd0, 8'd127, 8'd255, 8'd127};

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [10:0] cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;    // [11:0] new_centre
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;    // [9:0] pixel_index, [17:10] red, [25:18] green, [33:26] blue
	logic [1:0]  m_axis_tuser;    // [1:0] kind
	logic        m_axis_tlast;

	led_ripple_sparkle_frame uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// shadow of the block's ring and strip setting
	logic signed [CENTRE_W-1:0] centre_ring [RIPPLES];
	int                         ring_ptr;
	logic [CNT_CFG_W-1:0]       strip_cfg;

	led_beat_t frame_beats_due [$];
	int        fail_count;
	int        cycle_count;
	int        hold_request;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int strip_len();
		return (strip_cfg > MAX_PIXELS) ? MAX_PIXELS : int'(strip_cfg);
	endfunction

	function automatic void push_beat(kind_t k, int pix, int r, int g, int b, bit last);
		led_beat_t bt;
		bt.kind  = k;
		bt.pixel = pix[IDX_W-1:0];
		bt.red   = r[7:0];
		bt.green = g[7:0];
		bt.blue  = b[7:0];
		bt.last  = last;
		frame_beats_due.push_back(bt);
	endfunction

	function automatic void predict_frame(logic [CENTRE_W-1:0] centre);
		int len, slot, count, pos, r, g, b;
		len = strip_len();
		centre_ring[ring_ptr] = centre;
		push_beat(KIND_CLEAR, 0, 0, 0, 0, 1'b0);
		for (slot = 0; slot < RIPPLES; slot++) begin
			count = (ring_ptr + slot) % RIPPLES;
			if (count == 0) begin
				r = 255;
				g = 255;
				b = 255;
			end else begin
				r = int'(HUE_R[slot]) / count;
				g = int'(HUE_G[slot]) / count;
				b = int'(HUE_B[slot]) / count;
			end
			pos = int'(centre_ring[slot]) + count;
			if (pos >= 0 && pos < len)
				push_beat(KIND_SET, pos, r, g, b, 1'b0);
			pos = int'(centre_ring[slot]) - count;
			if (pos >= 0 && pos < len)
				push_beat(KIND_SET, pos, r, g, b, 1'b0);
		end
		push_beat(KIND_SHOW, 0, 0, 0, 0, 1'b1);
		ring_ptr = (ring_ptr + 1) % RIPPLES;
	endfunction

	function automatic void note_mismatch(string what, led_beat_t want, led_beat_t got);
		fail_count++;
		if (fail_count <= 10) begin
			$write("%0t %s: want kind=%0d pix=%0d rgb=%0d,%0d,%0d last=%0b", $realtime,
				what, want.kind, want.pixel, want.red, want.green, want.blue, want.last);
			$display(" | got kind=%0d pix=%0d rgb=%0d,%0d,%0d last=%0b",
				got.kind, got.pixel, got.red, got.green, got.blue, got.last);
		end
	endfunction

	function automatic logic [CENTRE_W-1:0] pick_centre();
		int len, v;
		len = strip_len();
		case ($urandom_range(0, 7))
			0: v = $urandom_range(0, 4095);
			1: v = int'($urandom_range(0, 12)) - 12;
			2: v = len - 1 + int'($urandom_range(0, 12));
			default: v = int'($urandom_range(0, len + 22)) - 12;
		endcase
		return v[CENTRE_W-1:0];
	endfunction

	// output beat checker
	always @(posedge clk) begin
		led_beat_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.kind  = kind_t'(m_axis_tuser);
			got.pixel = m_axis_tdata[9:0];
			got.red   = m_axis_tdata[17:10];
			got.green = m_axis_tdata[25:18];
			got.blue  = m_axis_tdata[33:26];
			got.last  = m_axis_tlast;
			if (frame_beats_due.size() == 0) begin
				note_mismatch("beat with nothing due", '0, got);
			end else begin
				want = frame_beats_due.pop_front();
				if (got.kind !== want.kind || got.pixel !== want.pixel ||
						got.red !== want.red || got.green !== want.green ||
						got.blue !== want.blue || got.last !== want.last)
					note_mismatch("beat mismatch", want, got);
			end
		end
	end

	// receiver: random duty stretches, plus long hold-offs on request
	initial begin
		int hold_left, duty, span;
		m_axis_tready = 1'b0;
		hold_left = 0;
		duty = 0;
		span = 0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (span == 0) begin
				duty = $urandom_range(0, 3);
				span = $urandom_range(16, 120);
			end
			span--;
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 3) >= duty);
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("led_ripple_sparkle_frame verification failed");
		$finish;
	end

	task automatic send_tick(input logic [CENTRE_W-1:0] centre, input bit keep_valid);
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'd0, centre};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_frame(centre);
		if (!keep_valid) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
	endtask

	task automatic send_random_ticks(input int total);
		int left, burst, k;
		left = total;
		while (left > 0) begin
			burst = $urandom_range(1, 12);
			if (burst > left)
				burst = left;
			for (k = 0; k < burst; k++)
				send_tick(pick_centre(), k < burst - 1);
			left -= burst;
			repeat ($urandom_range(0, 30)) @(negedge clk);
		end
	endtask

	// wait for every due beat, then let the block go idle
	task automatic settle();
		int waited;
		waited = 0;
		while (frame_beats_due.size() != 0 && waited < SETTLE_CAP) begin
			@(posedge clk);
			waited++;
		end
		repeat (FRAME_CYCLES + 4) @(posedge clk);
	endtask

	task automatic write_strip(input int len);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= len[CNT_CFG_W-1:0];
		@(negedge clk);
		cfg_we    <= 1'b0;
		strip_cfg = len[CNT_CFG_W-1:0];
	endtask

	task automatic test_edge_centres();
		int at_reset [8] = '{0, 59, 60, -1, -12, 70, -2048, 2047};
		int one_led  [4] = '{0, -1, 11, -11};
		int full_len [4] = '{1023, 1034, 0, 512};
		int over_len [3] = '{1023, -5, 1030};
		int no_led   [2] = '{0, 5};
		// reset strip length of 60
		foreach (at_reset[i])
			send_tick(at_reset[i][CENTRE_W-1:0], 1'b0);
		settle();
		write_strip(1);
		foreach (one_led[i])
			send_tick(one_led[i][CENTRE_W-1:0], 1'b0);
		settle();
		write_strip(MAX_PIXELS);
		foreach (full_len[i])
			send_tick(full_len[i][CENTRE_W-1:0], 1'b0);
		settle();
		// saturates to MAX_PIXELS
		write_strip(2047);
		foreach (over_len[i])
			send_tick(over_len[i][CENTRE_W-1:0], 1'b0);
		settle();
		write_strip(0);
		foreach (no_led[i])
			send_tick(no_led[i][CENTRE_W-1:0], 1'b0);
		settle();
	endtask

	task automatic test_random_frames();
		int lens [8] = '{0, 1, MAX_PIXELS, 0, 2047, 60, 16, MAX_PIXELS + 1};
		lens[0] = $urandom_range(2, MAX_PIXELS - 1);
		foreach (lens[i]) begin
			write_strip(lens[i]);
			send_random_ticks(28);
			settle();
		end
	endtask

	task automatic test_output_holdoff();
		int k;
		write_strip(MAX_PIXELS);
		hold_request = 400;
		@(negedge clk);
		@(negedge clk);
		for (k = 0; k < 6; k++)
			send_tick(pick_centre(), k < 5);
		settle();
	endtask

	task automatic test_drain_pause();
		write_strip($urandom_range(20, 200));
		send_random_ticks(10);
		settle();
		send_random_ticks(10);
		settle();
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		fail_count    = 0;
		hold_request  = 0;
		foreach (centre_ring[i])
			centre_ring[i] = '0;
		ring_ptr  = 0;
		strip_cfg = 11'd60;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_edge_centres();
		test_random_frames();
		test_output_holdoff();
		test_drain_pause();

		settle();
		while (frame_beats_due.size() != 0)
			note_mismatch("beat never came", frame_beats_due.pop_front(), '0);
		if (fail_count == 0)
			$display("led_ripple_sparkle_frame verification clean");
		else
			$display("led_ripple_sparkle_frame verification failed");
		$finish;
	end

endmodule
